/* src/ksc_pkg.sv */
package ksc_pkg;

  localparam int ALPHA_COUNT = 26;
  localparam int IDX_W       = $clog2(ALPHA_COUNT);
  localparam int TBL_DEPTH   = 1 << IDX_W;
  localparam int CHAR_W      = 8;
  localparam int KEY_W       = ALPHA_COUNT;

  localparam logic [CHAR_W-1:0] LETTER_A = 8'd65;
  localparam logic [CHAR_W-1:0] LETTER_Z = 8'd90;
  localparam logic [CHAR_W-1:0] CASE_GAP = 8'd32;
  localparam logic [IDX_W-1:0]  LAST_IDX = IDX_W'(ALPHA_COUNT - 1);

  // configuration register indexes
  typedef enum logic [0:0] {
    CFG_KEY_SET = 1'b0,
    CFG_DECRYPT = 1'b1
  } cfg_index_t;

  // table builder state
  typedef enum logic [0:0] {
    ST_BUILD = 1'b0,
    ST_RUN   = 1'b1
  } ctrl_state_t;

endpackage

/* src/keyword_substitution_cipher_core.sv */
// keyword substitution cipher on a byte stream
//
// channels: input bytes arrive on s_tvalid/s_tready/s_tdata, substituted bytes
// leave on m_tvalid/m_tready/m_tdata, one result request per input request.
// configuration writes come over cfg_valid/cfg_ready/cfg_index/cfg_data:
// index CFG_KEY_SET takes the 26-bit key letter set, index CFG_DECRYPT takes
// the mode in bit 0. write only while no byte is in flight.
//
// two 32x5 tables hold the forward cipher alphabet and its inverse. after
// reset and after every key write a builder sweeps the 26 letters, one per
// cycle, writing one entry of each table; while it runs s_tready and
// cfg_ready are low. a mode write needs no rebuild.
//
// an input request passes the table read, then the output register, on its way to
// m_tvalid. throughput is one byte per cycle outside a build and while the receiver
// keeps up, set by the single read port of each table. when the receiver stalls the
// output register holds, the read stage holds behind it, and s_tready drops once both are full.
module keyword_substitution_cipher_core import ksc_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  // input stream
  input  logic                s_tvalid,
  output logic                s_tready,
  input  logic [CHAR_W-1:0]   s_tdata,   // [7:0] in_char
  // output stream
  output logic                m_tvalid,
  input  logic                m_tready,
  output logic [CHAR_W-1:0]   m_tdata,   // [7:0] out_char
  // configuration writes
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  cfg_index_t          cfg_index,
  input  logic [KEY_W-1:0]    cfg_data
);

  // configuration registers
  logic [KEY_W-1:0] key_set;
  logic             decrypt;

  // table builder
  ctrl_state_t      state;
  ctrl_state_t      state_next;
  logic [IDX_W-1:0] build_idx;
  logic [IDX_W-1:0] below_cnt;   // key letters below build_idx
  logic [IDX_W-1:0] tbl_rank;
  logic             building;
  logic             key_write;

  // lookup pipeline
  logic              accept;
  logic              advance;
  logic              s1_valid;
  logic [CHAR_W-1:0] s1_char;
  logic              s1_letter;
  logic [CHAR_W-1:0] in_upper;
  logic              in_is_upper;
  logic              in_is_lower;
  logic [IDX_W-1:0]  in_pos;
  logic [IDX_W-1:0]  fwd_rd;
  logic [IDX_W-1:0]  inv_rd;
  logic [IDX_W-1:0]  sel_idx;
  logic [CHAR_W-1:0] out_char;

  // ---------------------------------------------------------------------
  // configuration
  // ---------------------------------------------------------------------
  assign cfg_ready = ~building;
  assign key_write = cfg_valid & cfg_ready & (cfg_index == CFG_KEY_SET);

  always_ff @(posedge clk) begin
    if (rst) begin
      key_set <= '0;
      decrypt <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_KEY_SET: key_set <= cfg_data;
        CFG_DECRYPT: decrypt <= cfg_data[0];
        default:     key_set <= key_set;
      endcase
    end
  end

  // ---------------------------------------------------------------------
  // table builder: key letters take ranks in ascending order, the others
  // follow from Z down to A, so an unused letter i lands at 25 - i plus the
  // key letters below it
  // ---------------------------------------------------------------------
  always_comb begin
    state_next = state;
    unique case (state)
      ST_BUILD: begin
        if (build_idx == LAST_IDX) begin
          state_next = ST_RUN;
        end
      end
      ST_RUN: begin
        if (key_write) begin
          state_next = ST_BUILD;
        end
      end
      default: state_next = ST_BUILD;
    endcase
  end

  always_comb begin
    building = 1'b0;
    unique case (state)
      ST_BUILD: building = 1'b1;
      ST_RUN:   building = 1'b0;
      default:  building = 1'b1;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_BUILD;
      build_idx <= '0;
      below_cnt <= '0;
    end else begin
      state <= state_next;
      if (building) begin
        build_idx <= build_idx + IDX_W'(1);
        below_cnt <= below_cnt + IDX_W'(key_set[build_idx]);
      end else begin
        build_idx <= '0;
        below_cnt <= '0;
      end
    end
  end

  assign tbl_rank = key_set[build_idx] ? below_cnt : (LAST_IDX - build_idx + below_cnt);

  // ---------------------------------------------------------------------
  // input decode
  // ---------------------------------------------------------------------
  assign in_is_upper = (s_tdata >= LETTER_A) && (s_tdata <= LETTER_Z);
  assign in_is_lower = (s_tdata >= LETTER_A + CASE_GAP) && (s_tdata <= LETTER_Z + CASE_GAP);
  assign in_upper    = in_is_lower ? (s_tdata - CASE_GAP) : s_tdata;
  assign in_pos      = IDX_W'(in_upper - LETTER_A);

  assign advance  = ~s1_valid | ~m_tvalid | m_tready;
  assign s_tready = ~building & advance;
  assign accept   = s_tvalid & s_tready;

  // forward table: rank -> letter index
  ksc_ram #(
    .WIDTH (IDX_W),
    .DEPTH (TBL_DEPTH)
  ) u_fwd_ram (
    .clk   (clk),
    .we    (building),
    .waddr (tbl_rank),
    .wdata (build_idx),
    .re    (accept),
    .raddr (in_pos),
    .rdata (fwd_rd)
  );

  // inverse table: letter index -> rank
  ksc_ram #(
    .WIDTH (IDX_W),
    .DEPTH (TBL_DEPTH)
  ) u_inv_ram (
    .clk   (clk),
    .we    (building),
    .waddr (build_idx),
    .wdata (tbl_rank),
    .re    (accept),
    .raddr (in_pos),
    .rdata (inv_rd)
  );

  // read stage, in step with the table read data
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (advance) begin
      s1_valid <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_char   <= in_upper;
      s1_letter <= in_is_upper | in_is_lower;
    end
  end

  // ---------------------------------------------------------------------
  // output register
  // ---------------------------------------------------------------------
  assign sel_idx  = decrypt ? inv_rd : fwd_rd;
  assign out_char = s1_letter ? (LETTER_A + CHAR_W'(sel_idx)) : s1_char;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (~m_tvalid | m_tready) begin
      m_tvalid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if ((~m_tvalid | m_tready) && s1_valid) begin
      m_tdata <= out_char;
    end
  end

  // ---------------------------------------------------------------------
  // assertions
  // ---------------------------------------------------------------------
  a_build_rank_range: assert property (@(posedge clk) disable iff (rst)
    building |-> (tbl_rank <= LAST_IDX))
    else $error("table rank out of range during build");

  a_below_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    building |-> (below_cnt <= build_idx))
    else $error("key letter count exceeds letters swept");

  a_build_ends: assert property (@(posedge clk) disable iff (rst)
    (building && build_idx == LAST_IDX) |=> (state == ST_RUN))
    else $error("table build did not finish after last letter");

  a_no_read_in_build: assert property (@(posedge clk) disable iff (rst)
    building |-> !accept)
    else $error("byte taken while tables are being built");

  a_s1_holds: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && !advance) |=> (s1_valid && $stable(s1_char) && $stable(s1_letter)))
    else $error("read stage lost its byte under stall");

endmodule

/* src/ksc_ram.sv */
module ksc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
